[sv/pgve_pkg.sv]
package pgve_pkg;

  localparam int unsigned IdW    = 31;
  localparam int unsigned FreqW  = 31;
  localparam int unsigned EntryW = IdW + FreqW;
  localparam int unsigned CodeW  = 40;
  localparam int unsigned LenW   = 3;
  localparam int unsigned GroupW = 7;
  localparam int unsigned MaxLen = 5;

  localparam logic KindAdd    = 1'b0;
  localparam logic KindFinish = 1'b1;

  localparam logic SecId   = 1'b0;
  localparam logic SecFreq = 1'b1;

  typedef struct packed {
    logic capture;
    logic set_ovf;
    logic ins_read;
    logic ins_shift;
    logic ins_place;
    logic emit_start;
    logic emit_read;
    logic emit_load;
  } pgve_cmd_t;

  typedef struct packed {
    logic full;
    logic j_zero;
    logic new_less;
    logic out_free;
    logic is_last;
  } pgve_status_t;

  typedef struct packed {
    logic [CodeW-1:0] word;
    logic [LenW-1:0]  len;
  } vb_code_t;

  function automatic vb_code_t vb_encode(input logic [IdW-1:0] v);
    vb_code_t                    res;
    logic [MaxLen*GroupW-1:0]    vp;
    logic [LenW-1:0]             n;
    vp = {{(MaxLen*GroupW-IdW){1'b0}}, v};
    if (vp[4*GroupW +: GroupW] != '0) begin
      n = LenW'(5);
    end else if (vp[3*GroupW +: GroupW] != '0) begin
      n = LenW'(4);
    end else if (vp[2*GroupW +: GroupW] != '0) begin
      n = LenW'(3);
    end else if (vp[GroupW +: GroupW] != '0) begin
      n = LenW'(2);
    end else begin
      n = LenW'(1);
    end
    res.word = '0;
    res.len  = n;
    for (int b = 0; b < MaxLen; b++) begin
      if (LenW'(b) < n) begin
        res.word[8*b +: 8] = {(LenW'(b + 1) < n), vp[GroupW*b +: GroupW]};
      end
    end
    return res;
  endfunction

endpackage

[sv/pgve_ram.sv]
module pgve_ram #(
  parameter int unsigned WIDTH = 62,
  parameter int unsigned DEPTH = 32
) (
  input  logic                                  clk_i,
  input  logic                                  we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                      wdata_i,
  input  logic                                  re_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                      rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[sv/pgve_ctrl.sv]
module pgve_ctrl
  import pgve_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  output logic         in_ready_o,
  input  logic         kind_i,
  input  pgve_status_t status_i,
  output pgve_cmd_t    cmd_o
);

  typedef enum logic [4:0] {
    StIdle  = 5'b00001,
    StInsRd = 5'b00010,
    StInsCmp = 5'b00100,
    StEmRd  = 5'b01000,
    StEmLd  = 5'b10000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (kind_i == KindFinish) begin
            cmd_o.emit_start = 1'b1;
            state_d          = StEmRd;
          end else if (status_i.full) begin
            cmd_o.set_ovf = 1'b1;
          end else begin
            cmd_o.capture = 1'b1;
            state_d       = StInsRd;
          end
        end
      end
      StInsRd: begin
        if (status_i.j_zero) begin
          cmd_o.ins_place = 1'b1;
          state_d         = StIdle;
        end else begin
          cmd_o.ins_read = 1'b1;
          state_d        = StInsCmp;
        end
      end
      StInsCmp: begin
        if (status_i.new_less) begin
          cmd_o.ins_shift = 1'b1;
          state_d         = StInsRd;
        end else begin
          cmd_o.ins_place = 1'b1;
          state_d         = StIdle;
        end
      end
      StEmRd: begin
        cmd_o.emit_read = 1'b1;
        state_d         = StEmLd;
      end
      StEmLd: begin
        if (status_i.out_free) begin
          cmd_o.emit_load = 1'b1;
          state_d         = status_i.is_last ? StIdle : StEmRd;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

[sv/pgve_dp.sv]
module pgve_dp
  import pgve_pkg::*;
#(
  parameter int unsigned DEPTH = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  pgve_cmd_t          cmd_i,
  output pgve_status_t       status_o,
  input  logic [IdW-1:0]     doc_id_i,
  input  logic [FreqW-1:0]   freq_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [CodeW-1:0]   code_word_o,
  output logic [LenW-1:0]    code_len_o,
  output logic               section_o,
  output logic               last_o,
  output logic [5:0]         posting_count_o,
  output logic [7:0]         id_bytes_o,
  output logic [7:0]         freq_bytes_o,
  output logic               dropped_o
);

  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam int unsigned AddrW = DEPTH > 1 ? $clog2(DEPTH) : 1;

  logic [CntW-1:0]   count_q, count_d;
  logic              ovf_q, ovf_d;
  logic [CntW-1:0]   j_q, j_d;
  logic [EntryW-1:0] new_q, new_d;
  logic [CntW-1:0]   idx_q, idx_d;
  logic              sec_q, sec_d;
  logic [IdW-1:0]    prev_id_q, prev_id_d;
  logic [7:0]        idb_q, idb_d;
  logic [7:0]        frb_q, frb_d;

  logic              out_valid_q, out_valid_d;
  logic [CodeW-1:0]  word_q, word_d;
  logic [LenW-1:0]   len_q, len_d;
  logic              section_q, section_d;
  logic              last_q, last_d;
  logic [5:0]        pcnt_q, pcnt_d;
  logic [7:0]        idbo_q, idbo_d;
  logic [7:0]        frbo_q, frbo_d;
  logic              drop_q, drop_d;

  logic [CntW-1:0]   j_m1;
  logic [CntW-1:0]   cnt_m1;
  logic              ram_we;
  logic              ram_re;
  logic [AddrW-1:0]  ram_raddr;
  logic [EntryW-1:0] ram_wdata;
  logic [EntryW-1:0] rdata;
  logic [IdW-1:0]    rd_id;
  logic [FreqW-1:0]  rd_fr;
  logic [IdW-1:0]    code_val;
  vb_code_t          enc;
  logic              is_empty;
  logic              idx_last;
  logic              is_last;
  logic              out_free;

  assign j_m1      = j_q - CntW'(1);
  assign cnt_m1    = count_q - CntW'(1);
  assign ram_we    = cmd_i.ins_shift | cmd_i.ins_place;
  assign ram_re    = cmd_i.ins_read | cmd_i.emit_read;
  assign ram_raddr = cmd_i.ins_read ? j_m1[AddrW-1:0] : idx_q[AddrW-1:0];
  assign ram_wdata = cmd_i.ins_shift ? rdata : new_q;

  pgve_ram #(
    .WIDTH (EntryW),
    .DEPTH (DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (j_q[AddrW-1:0]),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (rdata)
  );

  assign rd_id    = rdata[EntryW-1:FreqW];
  assign rd_fr    = rdata[FreqW-1:0];
  assign is_empty = (count_q == '0);
  assign idx_last = (idx_q == cnt_m1);
  assign is_last  = is_empty | ((sec_q == SecFreq) & idx_last);
  assign out_free = ~out_valid_q | out_ready_i;

  // first id raw, then gaps, then frequencies
  always_comb begin
    if (sec_q == SecFreq) begin
      code_val = rd_fr;
    end else if (idx_q == '0) begin
      code_val = rd_id;
    end else begin
      code_val = rd_id - prev_id_q;
    end
  end

  assign enc = vb_encode(code_val);

  always_comb begin
    count_d     = count_q;
    ovf_d       = ovf_q;
    j_d         = j_q;
    new_d       = new_q;
    idx_d       = idx_q;
    sec_d       = sec_q;
    prev_id_d   = prev_id_q;
    idb_d       = idb_q;
    frb_d       = frb_q;
    out_valid_d = out_valid_q & ~out_ready_i;
    word_d      = word_q;
    len_d       = len_q;
    section_d   = section_q;
    last_d      = last_q;
    pcnt_d      = pcnt_q;
    idbo_d      = idbo_q;
    frbo_d      = frbo_q;
    drop_d      = drop_q;

    if (cmd_i.set_ovf) begin
      ovf_d = 1'b1;
    end
    if (cmd_i.capture) begin
      new_d = {doc_id_i, freq_i};
      j_d   = count_q;
    end
    if (cmd_i.ins_shift) begin
      j_d = j_m1;
    end
    if (cmd_i.ins_place) begin
      count_d = count_q + CntW'(1);
    end
    if (cmd_i.emit_start) begin
      idx_d = '0;
      sec_d = SecId;
      idb_d = '0;
      frb_d = '0;
    end
    if (cmd_i.emit_load) begin
      out_valid_d = 1'b1;
      word_d      = is_empty ? '0 : enc.word;
      len_d       = is_empty ? '0 : enc.len;
      section_d   = is_empty ? SecId : sec_q;
      last_d      = is_last;
      pcnt_d      = is_last ? 6'(count_q) : '0;
      idbo_d      = is_last ? idb_q : '0;
      frbo_d      = is_last ? (is_empty ? '0 : frb_q + 8'(enc.len)) : '0;
      drop_d      = is_last ? ovf_q : 1'b0;
      if (sec_q == SecId) begin
        idb_d     = idb_q + 8'(enc.len);
        prev_id_d = rd_id;
      end else begin
        frb_d = frb_q + 8'(enc.len);
      end
      if (idx_last && (sec_q == SecId)) begin
        sec_d = SecFreq;
        idx_d = '0;
      end else begin
        idx_d = idx_q + CntW'(1);
      end
      if (is_last) begin
        count_d = '0;
        ovf_d   = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      ovf_q       <= ovf_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    j_q       <= j_d;
    new_q     <= new_d;
    idx_q     <= idx_d;
    sec_q     <= sec_d;
    prev_id_q <= prev_id_d;
    idb_q     <= idb_d;
    frb_q     <= frb_d;
    word_q    <= word_d;
    len_q     <= len_d;
    section_q <= section_d;
    last_q    <= last_d;
    pcnt_q    <= pcnt_d;
    idbo_q    <= idbo_d;
    frbo_q    <= frbo_d;
    drop_q    <= drop_d;
  end

  assign status_o.full     = (count_q == CntW'(DEPTH));
  assign status_o.j_zero   = (j_q == '0);
  assign status_o.new_less = (new_q < rdata);
  assign status_o.out_free = out_free;
  assign status_o.is_last  = is_last;

  assign out_valid_o     = out_valid_q;
  assign code_word_o     = word_q;
  assign code_len_o      = len_q;
  assign section_o       = section_q;
  assign last_o          = last_q;
  assign posting_count_o = pcnt_q;
  assign id_bytes_o      = idbo_q;
  assign freq_bytes_o    = frbo_q;
  assign dropped_o       = drop_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(DEPTH))
    else $error("posting count above depth");

  a_place_not_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.ins_place |-> count_q < CntW'(DEPTH))
    else $error("insert into full store");

  a_load_into_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit_load |-> out_free)
    else $error("result overwritten before taken");

  a_empty_only_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (len_q == '0)) |-> (last_q && (pcnt_q == '0)))
    else $error("zero length code on a non-empty list");

endmodule

[sv/postings_gap_varbyte_encoder.sv]
// Posting list variable-byte gap encoder. Each add (kind 0) inserts its
// (doc_id, freq) pair into a sorted store by walking it from the top:
// each entry moved costs a store read and a compare, and the new entry is
// written where the walk stops; no new word is accepted until it is placed.
// An add to a full store is dropped and flagged on the last result of the
// list. A finish (kind 1) walks the store twice, first emitting the first id
// then id gaps, then every frequency, one code per output word; each result
// is a store read, then an encode into the output register, which waits
// until the output register is free. An empty finish yields one word with
// code_len 0. The last word carries the posting count, both section byte
// totals and the dropped flag, and the store is empty again afterwards.
// No clearing pass after reset.
module postings_gap_varbyte_encoder
  import pgve_pkg::*;
#(
  parameter int unsigned DEPTH = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               kind_i,
  input  logic [IdW-1:0]     doc_id_i,
  input  logic [FreqW-1:0]   freq_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [CodeW-1:0]   code_word_o,
  output logic [LenW-1:0]    code_len_o,
  output logic               section_o,
  output logic               last_o,
  output logic [5:0]         posting_count_o,
  output logic [7:0]         id_bytes_o,
  output logic [7:0]         freq_bytes_o,
  output logic               dropped_o
);

  pgve_cmd_t    cmd;
  pgve_status_t status;

  pgve_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .kind_i     (kind_i),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  pgve_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .status_o        (status),
    .doc_id_i        (doc_id_i),
    .freq_i          (freq_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .code_word_o     (code_word_o),
    .code_len_o      (code_len_o),
    .section_o       (section_o),
    .last_o          (last_o),
    .posting_count_o (posting_count_o),
    .id_bytes_o      (id_bytes_o),
    .freq_bytes_o    (freq_bytes_o),
    .dropped_o       (dropped_o)
  );

endmodule

[sim/gap_code_checker.sv]
`timescale 1ns / 1ps
module gap_code_checker
  import pgve_pkg::*;
#(
  parameter int unsigned DEPTH = 32
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic             in_ready_i,
  input  logic             kind_i,
  input  logic [IdW-1:0]   doc_id_i,
  input  logic [FreqW-1:0] freq_i,
  input  logic             out_valid_i,
  input  logic             out_ready_i,
  input  logic [CodeW-1:0] code_word_i,
  input  logic [LenW-1:0]  code_len_i,
  input  logic             section_i,
  input  logic             last_i,
  input  logic [5:0]       posting_count_i,
  input  logic [7:0]       id_bytes_i,
  input  logic [7:0]       freq_bytes_i,
  input  logic             dropped_i,
  output int               errors_o,
  output int               pending_o,
  output int               words_o
);

  typedef struct packed {
    logic [CodeW-1:0] word;
    logic [LenW-1:0]  len;
    logic             section;
    logic             last;
    logic [5:0]       count;
    logic [7:0]       id_bytes;
    logic [7:0]       freq_bytes;
    logic             dropped;
  } gap_code_t;

  gap_code_t        expected_codes[$];
  logic [IdW-1:0]   held_id[DEPTH];
  logic [FreqW-1:0] held_freq[DEPTH];
  int unsigned      held_n;
  logic             overflow;
  int               mismatches;
  int               checked;

  function automatic void varbyte(input logic [IdW-1:0] v, output logic [CodeW-1:0] w,
                                  output logic [LenW-1:0] n);
    logic [IdW-1:0] rest;
    rest = v;
    w    = '0;
    n    = '0;
    while (rest >= IdW'(128)) begin
      w[8*n +: 8] = {1'b1, rest[6:0]};
      rest        = rest >> GroupW;
      n++;
    end
    w[8*n +: 8] = {1'b0, rest[6:0]};
    n++;
  endfunction

  // sort the held postings, then queue the id gap codes and the frequency codes
  task automatic predict_list_codes();
    gap_code_t        c;
    logic [IdW-1:0]   ti;
    logic [FreqW-1:0] tf;
    int               i;
    int               j;
    int unsigned      idb;
    int unsigned      frb;
    idb = 0;
    frb = 0;
    for (i = 1; i < int'(held_n); i++) begin
      ti = held_id[i];
      tf = held_freq[i];
      j  = i;
      while (j > 0 && (ti < held_id[j-1] || (ti == held_id[j-1] && tf < held_freq[j-1]))) begin
        held_id[j]   = held_id[j-1];
        held_freq[j] = held_freq[j-1];
        j--;
      end
      held_id[j]   = ti;
      held_freq[j] = tf;
    end
    c = '0;
    if (held_n == 0) begin
      expected_codes = {expected_codes, c};
    end else begin
      for (i = 0; i < int'(held_n); i++) begin
        c = '0;
        c.section = SecId;
        varbyte((i == 0) ? held_id[0] : held_id[i] - held_id[i-1], c.word, c.len);
        idb += c.len;
        expected_codes = {expected_codes, c};
      end
      for (i = 0; i < int'(held_n); i++) begin
        c = '0;
        c.section = SecFreq;
        varbyte(held_freq[i], c.word, c.len);
        frb += c.len;
        expected_codes = {expected_codes, c};
      end
    end
    c            = expected_codes.pop_back();
    c.last       = 1'b1;
    c.count      = 6'(held_n);
    c.id_bytes   = 8'(idb);
    c.freq_bytes = 8'(frb);
    c.dropped    = overflow;
    expected_codes = {expected_codes, c};
    held_n   = 0;
    overflow = 1'b0;
  endtask

  task automatic check_field(input string name, input logic [CodeW-1:0] exp_v,
                             input logic [CodeW-1:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s: expected %0h, got %0h", name, exp_v, act_v);
      mismatches++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    gap_code_t e;
    if (!rst_ni) begin
      expected_codes.delete();
      held_n     = 0;
      overflow   = 1'b0;
      mismatches = 0;
      checked    = 0;
      errors_o  <= 0;
      pending_o <= 0;
      words_o   <= 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        checked++;
        if (expected_codes.size() == 0) begin
          $error("code word %0h with none expected", code_word_i);
          mismatches++;
        end else begin
          e = expected_codes.pop_front();
          check_field("code_word", e.word, code_word_i);
          check_field("code_len", CodeW'(e.len), CodeW'(code_len_i));
          check_field("section", CodeW'(e.section), CodeW'(section_i));
          check_field("last", CodeW'(e.last), CodeW'(last_i));
          check_field("posting_count", CodeW'(e.count), CodeW'(posting_count_i));
          check_field("id_bytes", CodeW'(e.id_bytes), CodeW'(id_bytes_i));
          check_field("freq_bytes", CodeW'(e.freq_bytes), CodeW'(freq_bytes_i));
          check_field("dropped", CodeW'(e.dropped), CodeW'(dropped_i));
        end
      end
      if (in_valid_i && in_ready_i) begin
        if (kind_i == KindAdd) begin
          if (held_n >= DEPTH) begin
            overflow = 1'b1;
          end else begin
            held_id[held_n]   = doc_id_i;
            held_freq[held_n] = freq_i;
            held_n++;
          end
        end else begin
          predict_list_codes();
        end
      end
      errors_o  <= mismatches;
      pending_o <= expected_codes.size();
      words_o   <= checked;
    end
  end

endmodule

[sim/testbench.sv]
`timescale 1ns / 1ps
module testbench;
  import pgve_pkg::*;

  localparam int unsigned DEPTH      = 32;
  localparam int          QUIET_MAX  = 5000;
  localparam logic [IdW-1:0] MaxVal  = '1;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_ready;
  logic             kind = KindAdd;
  logic [IdW-1:0]   doc_id = '0;
  logic [FreqW-1:0] freq = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  logic [CodeW-1:0] code_word;
  logic [LenW-1:0]  code_len;
  logic             section;
  logic             last;
  logic [5:0]       posting_count;
  logic [7:0]       id_bytes;
  logic [7:0]       freq_bytes;
  logic             dropped;

  int errors;
  int pending;
  int words;
  int idle_pct = 12;
  int stall_pct = 54;
  int quiet;
  int adds;
  int lists;
  int full_lists;

  postings_gap_varbyte_encoder #(.DEPTH(DEPTH)) dut (
    .clk_i, .rst_ni,
    .in_valid_i(in_valid), .in_ready_o(in_ready),
    .kind_i(kind), .doc_id_i(doc_id), .freq_i(freq),
    .out_valid_o(out_valid), .out_ready_i(out_ready),
    .code_word_o(code_word), .code_len_o(code_len), .section_o(section),
    .last_o(last), .posting_count_o(posting_count), .id_bytes_o(id_bytes),
    .freq_bytes_o(freq_bytes), .dropped_o(dropped)
  );

  gap_code_checker #(.DEPTH(DEPTH)) u_checker (
    .clk_i, .rst_ni,
    .in_valid_i(in_valid), .in_ready_i(in_ready),
    .kind_i(kind), .doc_id_i(doc_id), .freq_i(freq),
    .out_valid_i(out_valid), .out_ready_i(out_ready),
    .code_word_i(code_word), .code_len_i(code_len), .section_i(section),
    .last_i(last), .posting_count_i(posting_count), .id_bytes_i(id_bytes),
    .freq_bytes_i(freq_bytes), .dropped_i(dropped),
    .errors_o(errors), .pending_o(pending), .words_o(words)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    out_ready <= ($urandom_range(0, 99) >= stall_pct);
  end

  always @(posedge clk_i) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
    end
    if (quiet >= QUIET_MAX) begin
      $display("timeout: no word moved for %0d cycles", quiet);
      $display("** postings_gap_varbyte_encoder: FAILED **");
      $finish;
    end
  end

  function automatic logic [IdW-1:0] pick_value();
    case ($urandom_range(0, 5))
      0:       return IdW'($urandom_range(0, 3));
      1:       return MaxVal;
      default: return IdW'($urandom >> $urandom_range(1, 31));
    endcase
  endfunction

  task automatic send_word(input logic k, input logic [IdW-1:0] id, input logic [FreqW-1:0] f);
    int gap;
    gap = 0;
    while ($urandom_range(0, 99) < idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    kind     <= k;
    doc_id   <= id;
    freq     <= f;
    do @(posedge clk_i); while (!in_ready);
    if (k == KindAdd) begin
      adds++;
    end else begin
      lists++;
    end
  endtask

  task automatic send_list(input int size);
    for (int i = 0; i < size; i++) begin
      send_word(KindAdd, pick_value(), pick_value());
    end
    if (size > int'(DEPTH)) full_lists++;
    send_word(KindFinish, pick_value(), pick_value());
  endtask

  function automatic int pick_list_size();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return 0;
    if (r == 1) return $urandom_range(29, 35);
    if (r < 5) return $urandom_range(9, 16);
    return $urandom_range(1, 8);
  endfunction

  initial begin
    int phase_end;
    quiet = 0;
    adds = 0;
    lists = 0;
    full_lists = 0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // empty list, then a single zero posting
    send_word(KindFinish, MaxVal, MaxVal);
    send_word(KindAdd, '0, '0);
    send_word(KindFinish, '0, '0);

    // group boundaries, equal ids, descending arrival
    send_word(KindAdd, MaxVal, MaxVal);
    send_word(KindAdd, 31'd268435455, 31'd268435456);
    send_word(KindAdd, 31'd2097151, 31'd2097152);
    send_word(KindAdd, 31'd16383, 31'd16384);
    send_word(KindAdd, 31'd128, 31'd127);
    send_word(KindAdd, 31'd127, 31'd128);
    send_word(KindAdd, 31'd127, 31'd0);
    send_word(KindAdd, 31'd127, 31'd0);
    send_word(KindAdd, 31'd5, MaxVal);
    send_word(KindFinish, '0, '0);

    // a full list with dropped adds
    send_list($urandom_range(33, 35));

    for (int phase = 0; phase < 3; phase++) begin
      idle_pct  = (phase == 0) ? 12 : (phase == 1) ? 54 : 0;
      stall_pct = (phase == 0) ? 54 : (phase == 1) ? 12 : 0;
      phase_end = adds + lists + 22;
      while (adds + lists < phase_end) begin
        send_list(pick_list_size());
      end
    end

    in_valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (20) @(posedge clk_i);

    $display("covered %0d adds over %0d lists, %0d of them past capacity",
             adds, lists, full_lists);
    $display("%0d code words checked under three idle/stall mixes", words);
    if (errors == 0 && pending == 0) begin
      $display("** postings_gap_varbyte_encoder: PASSED **");
    end else begin
      $display("** postings_gap_varbyte_encoder: FAILED **");
    end
    $finish;
  end

endmodule

[filelist.f]
sv/pgve_pkg.sv
sv/pgve_ram.sv
sv/pgve_ctrl.sv
sv/pgve_dp.sv
sv/postings_gap_varbyte_encoder.sv
sim/gap_code_checker.sv
sim/testbench.sv
